### rtl/mbps_pkg.sv
// Shared types and constants for the masked byte pattern scanner.
`default_nettype none

package mbps_pkg;

   localparam int PATTERN_BYTES = 16;
   localparam int LEN_W         = 5;
   localparam int COUNT_W       = 34;
   localparam int ADDR_W        = 64;
   localparam int SCAN_W        = 32;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_INDEX_W   = 3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_PATTERN_LOW  = 3'd0,
      REG_PATTERN_HIGH = 3'd1,
      REG_CARE_BITS    = 3'd2,
      REG_PATTERN_LEN  = 3'd3,
      REG_BASE_ADDRESS = 3'd4,
      REG_SCAN_LENGTH  = 3'd5
   } csr_index_type;

   typedef logic [PATTERN_BYTES-1:0][7:0] byte_row_type;

   typedef struct packed {
      byte_row_type               pattern;
      logic [PATTERN_BYTES-1:0]   care;
      logic [LEN_W-1:0]           length;
   } pattern_cfg_type;

   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] match_address;
   } rsp_item_type;

endpackage

`default_nettype wire

### rtl/mbps_req_if.sv
// Input byte channel: valid/ready handshake with one scanned byte per transfer.
`default_nettype none

interface mbps_req_if
   import mbps_pkg::*;
();
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last;

   modport source (output valid, output data_byte, output last, input ready);
   modport sink   (input valid, input data_byte, input last, output ready);
endinterface

`default_nettype wire

### rtl/mbps_rsp_if.sv
// Result channel: valid/ready handshake carrying found flag and match address.
`default_nettype none

interface mbps_rsp_if
   import mbps_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              found;
   logic [ADDR_W-1:0] match_address;

   modport source (output valid, output found, output match_address, input ready);
   modport sink   (input valid, input found, input match_address, output ready);
endinterface

`default_nettype wire

### rtl/mbps_window_compare.sv
// Masked compare of the byte window against the pattern.
`default_nettype none

module mbps_window_compare
   import mbps_pkg::*;
(
   input  wire byte_row_type    window,
   input  wire pattern_cfg_type cfg,
   output logic                 hit
);

   logic [PATTERN_BYTES-1:0] mismatch;

   // Window entry 0 is the newest byte, so pattern byte k sits at length-1-k.
   always_comb begin
      logic [LEN_W-1:0] pos;
      for (int k = 0; k < PATTERN_BYTES; k++) begin
         pos = cfg.length - LEN_W'(1) - LEN_W'(k);
         mismatch[k] = (LEN_W'(k) < cfg.length) && cfg.care[k] &&
                       (window[pos[3:0]] != cfg.pattern[k]);
      end
   end

   assign hit = ~|mismatch;

endmodule

`default_nettype wire

### rtl/masked_byte_pattern_scanner.sv
// Masked byte pattern scanner: one byte per cycle unless the skid entry is full; reports
// the first match of a stream, or not found on its last byte, via the output register.
// Throughput: one byte per cycle while the skid entry is empty; compare is combinational.
// Output register plus a skid entry let bytes keep flowing while a result waits.
// Reset (synchronous, active high) clears the registers to their defaults
// (pattern length 1), the byte count, the match flag and both output entries.
`default_nettype none

module masked_byte_pattern_scanner
   import mbps_pkg::*;
#(
   parameter int MAX_PATTERN = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   mbps_req_if.sink                     req_ch,
   mbps_rsp_if.source                   rsp_ch,
   input  wire                          csr_write_en,
   input  wire [CSR_INDEX_W-1:0]        csr_index,
   input  wire [CSR_DATA_W-1:0]         csr_wdata
);

   localparam int              CAP     = (MAX_PATTERN < PATTERN_BYTES) ? MAX_PATTERN
                                                                       : PATTERN_BYTES;
   localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(CAP);

   // Configuration registers
   logic [63:0]              pat_low_ff;
   logic [63:0]              pat_high_ff;
   logic [PATTERN_BYTES-1:0] care_ff;
   logic [LEN_W-1:0]         length_ff;
   logic [ADDR_W-1:0]        base_ff;
   logic [SCAN_W-1:0]        scan_ff;

   // Stream state
   logic [7:0]               window_ff [MAX_PATTERN];
   logic [7:0]               window_in [MAX_PATTERN];
   logic [COUNT_W-1:0]       seen_ff, seen_in;
   logic                     reported_ff, reported_in;

   // Output register and skid entry
   rsp_item_type             out_ff, out_in;
   logic                     out_valid_ff, out_valid_in;
   rsp_item_type             skid_ff, skid_in;
   logic                     skid_valid_ff, skid_valid_in;

   logic                     accept;
   logic [LEN_W-1:0]         eff_len;
   logic [COUNT_W-1:0]       seen_next;
   logic [COUNT_W-1:0]       len_ext;
   logic [COUNT_W-1:0]       start;
   logic                     window_full;
   logic                     in_scan;
   logic                     hit;
   logic                     fire;
   logic                     push;
   rsp_item_type             result;
   byte_row_type             cmp_window;
   pattern_cfg_type          cmp_cfg;
   logic                     out_free;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         care_ff     <= '0;
         length_ff   <= LEN_W'(1);
         base_ff     <= '0;
         scan_ff     <= '0;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            REG_PATTERN_LOW:  pat_low_ff  <= csr_wdata;
            REG_PATTERN_HIGH: pat_high_ff <= csr_wdata;
            REG_CARE_BITS:    care_ff     <= csr_wdata[PATTERN_BYTES-1:0];
            REG_PATTERN_LEN:  length_ff   <= csr_wdata[LEN_W-1:0];
            REG_BASE_ADDRESS: base_ff     <= csr_wdata;
            REG_SCAN_LENGTH:  scan_ff     <= csr_wdata[SCAN_W-1:0];
            default: ;
         endcase
      end
   end

   // Zero length acts as one; anything above the window cap is clamped.
   always_comb begin
      if (length_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (length_ff > LEN_CAP) begin
         eff_len = LEN_CAP;
      end else begin
         eff_len = length_ff;
      end
   end

   // ---------------------------------------------------------------- window
   assign accept = req_ch.valid && req_ch.ready;

   always_comb begin
      window_in[0] = req_ch.data_byte;
      for (int i = 1; i < MAX_PATTERN; i++) begin
         window_in[i] = window_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         window_ff <= window_in;
      end
   end

   always_comb begin
      for (int i = 0; i < PATTERN_BYTES; i++) begin
         cmp_window[i] = (i < MAX_PATTERN) ? window_in[i] : 8'h00;
      end
   end

   assign cmp_cfg.pattern = {pat_high_ff, pat_low_ff};
   assign cmp_cfg.care    = care_ff;
   assign cmp_cfg.length  = eff_len;

   mbps_window_compare u_compare (
      .window (cmp_window),
      .cfg    (cmp_cfg),
      .hit    (hit)
   );

   // ---------------------------------------------------------------- match
   assign seen_next   = (seen_ff == COUNT_MAX) ? seen_ff : seen_ff + COUNT_W'(1);
   assign len_ext     = COUNT_W'(eff_len);
   assign window_full = seen_next >= len_ext;
   assign start       = seen_next - len_ext;
   assign in_scan     = start < COUNT_W'(scan_ff);

   assign fire = accept && !reported_ff && window_full && in_scan && hit;
   assign push = fire || (accept && req_ch.last && !reported_ff);

   assign result.found         = fire;
   assign result.match_address = fire ? base_ff + ADDR_W'(start) : '0;

   // Clear the stream state after the last byte.
   always_comb begin
      seen_in     = seen_ff;
      reported_in = reported_ff;
      if (accept) begin
         if (req_ch.last) begin
            seen_in     = '0;
            reported_in = 1'b0;
         end else begin
            seen_in     = seen_next;
            reported_in = reported_ff || fire;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff     <= '0;
         reported_ff <= 1'b0;
      end else begin
         seen_ff     <= seen_in;
         reported_ff <= reported_in;
      end
   end

   // ---------------------------------------------------------------- output
   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !skid_valid_ff;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            // advance the skid entry; no new item arrives while it is full
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = result;
            out_valid_in = push;
         end
      end else if (push) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.found         = out_ff.found;
   assign rsp_ch.match_address = out_ff.match_address;

   // ---------------------------------------------------------------- checks
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a result while the output register is empty");

   a_last_clears_count: assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.last) |=> (seen_ff == '0 && !reported_ff))
      else $error("stream state not cleared after the last byte");

   a_one_result_per_stream: assert property (@(posedge clock) disable iff (reset)
      (accept && reported_ff) |-> !push)
      else $error("second result produced in one stream");

   a_no_match_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.found) |-> (out_ff.match_address == '0))
      else $error("no-match result carries a nonzero address");

   a_match_needs_window: assert property (@(posedge clock) disable iff (reset)
      fire |-> (seen_next >= len_ext && start < COUNT_W'(scan_ff)))
      else $error("match reported outside the allowed start range");

endmodule

`default_nettype wire

### tb/testbench.sv
// Testbench for the masked byte pattern scanner: byte streams checked against a local predictor.
`timescale 1ns / 100ps

module testbench;
   import mbps_pkg::*;

   localparam int ITEM_TARGET   = 1400;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 4;
   localparam int LONG_HOLD     = 60;

   class match_scoreboard;
      logic [CSR_DATA_W-1:0]    pattern_low;
      logic [CSR_DATA_W-1:0]    pattern_high;
      logic [PATTERN_BYTES-1:0] care;
      logic [LEN_W-1:0]         pattern_len;
      logic [ADDR_W-1:0]        base_address;
      logic [SCAN_W-1:0]        scan_length;
      logic [7:0]               window [PATTERN_BYTES];
      logic [COUNT_W-1:0]       bytes_seen;
      bit                       matched;
      rsp_item_type             due_reports[$];
      int                       errors;
      int                       hits;
      int                       misses;

      function void clear_stream();
         foreach (window[i]) window[i] = 8'h00;
         bytes_seen = '0;
         matched = 1'b0;
      endfunction

      function void reset_regs();
         pattern_low = '0;
         pattern_high = '0;
         care = '0;
         pattern_len = LEN_W'(1);
         base_address = '0;
         scan_length = '0;
         errors = 0;
         hits = 0;
         misses = 0;
         clear_stream();
      endfunction

      // zero acts as one, anything past the window acts as a full window
      function int active_length();
         if (pattern_len == 0) return 1;
         if (pattern_len > PATTERN_BYTES) return PATTERN_BYTES;
         return int'(pattern_len);
      endfunction

      function logic [7:0] pattern_byte(int k);
         logic [2*CSR_DATA_W-1:0] both;
         both = {pattern_high, pattern_low};
         return both[8*k +: 8];
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] v);
         case (idx)
            REG_PATTERN_LOW:  pattern_low = v;
            REG_PATTERN_HIGH: pattern_high = v;
            REG_CARE_BITS:    care = v[PATTERN_BYTES-1:0];
            REG_PATTERN_LEN:  pattern_len = v[LEN_W-1:0];
            REG_BASE_ADDRESS: base_address = v;
            REG_SCAN_LENGTH:  scan_length = v[SCAN_W-1:0];
            default: ;
         endcase
      endfunction

      function void absorb_byte(logic [7:0] b, logic is_last);
         int                 len;
         logic [COUNT_W-1:0] start;
         bit                 ok;
         bit                 hit;
         rsp_item_type       r;
         len = active_length();
         hit = 1'b0;
         for (int i = PATTERN_BYTES - 1; i > 0; i--) window[i] = window[i-1];
         window[0] = b;
         if (bytes_seen != COUNT_MAX) bytes_seen++;
         if (!matched && bytes_seen >= len) begin
            start = bytes_seen - COUNT_W'(len);
            if (start < {2'b00, scan_length}) begin
               ok = 1'b1;
               for (int k = 0; k < len; k++)
                  if (care[k] && window[len-1-k] != pattern_byte(k)) ok = 1'b0;
               if (ok) begin
                  matched = 1'b1;
                  hit = 1'b1;
                  hits++;
                  r.found = 1'b1;
                  r.match_address = base_address + ADDR_W'(start);
                  due_reports.push_back(r);
               end
            end
         end
         if (is_last) begin
            if (!hit && !matched) begin
               misses++;
               r.found = 1'b0;
               r.match_address = '0;
               due_reports.push_back(r);
            end
            clear_stream();
         end
      endfunction

      task report_mismatch(string what, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
         $display("mismatch on %s: got %h, expected %h", what, got, want);
         errors++;
      endtask

      task check_result(logic found, logic [ADDR_W-1:0] addr);
         rsp_item_type want;
         if (due_reports.size() == 0) begin
            report_mismatch("result with none pending", addr, '0);
            return;
         end
         want = due_reports.pop_front();
         if (found !== want.found) report_mismatch("found", ADDR_W'(found), ADDR_W'(want.found));
         if (addr !== want.match_address) report_mismatch("match_address", addr, want.match_address);
      endtask

      task flush_leftovers();
         rsp_item_type r;
         while (due_reports.size() != 0) begin
            r = due_reports.pop_front();
            report_mismatch("result never arrived", '0, r.match_address);
         end
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_write_en;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   mbps_req_if req_ch();
   mbps_rsp_if rsp_ch();

   masked_byte_pattern_scanner DUT (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   match_scoreboard sb;
   logic [7:0]      stream_q[$];
   int              cycles;
   int              items_sent;
   int              streams_sent;
   int              settings_used;
   int              holds_done;
   int              hold_request;
   bit              steady;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
         sb.check_result(rsp_ch.found, rsp_ch.match_address);
   end

   // result side: random stalls, plus a long hold on request
   initial begin
      int hold_left;
      bit calm;
      hold_left = 0;
      calm = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         calm = steady;
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
            holds_done++;
         end
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= calm || ($urandom_range(99) >= 25);
         end
      end
   end

   task automatic send_byte(logic [7:0] b, logic is_last);
      int gap;
      gap = 0;
      if (!steady)
         while (gap < 6 && $urandom_range(99) < 25) gap++;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.last <= is_last;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sb.absorb_byte(b, is_last);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_stream();
      foreach (stream_q[i]) send_byte(stream_q[i], i == stream_q.size() - 1);
      streams_sent++;
   endtask

   // drop valid, wait out every pending result and any result still in flight
   task automatic drain_and_settle();
      req_ch.valid <= 1'b0;
      while (sb.due_reports.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] v);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
      sb.write_reg(idx, v);
   endtask

   task automatic configure(logic [63:0] lo, logic [63:0] hi, logic [15:0] care_v,
                            logic [4:0] len, logic [63:0] base, logic [31:0] scan);
      logic [63:0] junk;
      junk = {$urandom, $urandom};
      csr_write(REG_PATTERN_LOW, lo);
      csr_write(REG_PATTERN_HIGH, hi);
      csr_write(REG_CARE_BITS, {junk[63:16], care_v});
      csr_write(REG_PATTERN_LEN, {junk[63:5], len});
      csr_write(REG_BASE_ADDRESS, base);
      csr_write(REG_SCAN_LENGTH, {junk[63:32], scan});
      csr_write_en <= 1'b0;
      settings_used++;
   endtask

   task automatic choose_setting();
      logic [63:0] lo, hi, base;
      logic [15:0] care_v;
      logic [4:0]  len;
      logic [31:0] scan;
      case ($urandom_range(5))
         0: lo = '0;
         1: lo = '1;
         default: lo = {$urandom, $urandom};
      endcase
      case ($urandom_range(5))
         0: hi = '0;
         1: hi = '1;
         default: hi = {$urandom, $urandom};
      endcase
      case ($urandom_range(5))
         0: care_v = '0;
         1: care_v = '1;
         default: care_v = 16'($urandom);
      endcase
      case ($urandom_range(9))
         0: len = 5'd0;
         1: len = 5'd1;
         2: len = 5'd16;
         3: len = 5'($urandom_range(31, 17));
         default: len = 5'($urandom_range(16, 1));
      endcase
      case ($urandom_range(4))
         0: base = '0;
         1: base = '1;
         2: base = 64'hFFFF_FFFF_FFFF_FFF0 + 64'($urandom_range(15));
         default: base = {$urandom, $urandom};
      endcase
      case ($urandom_range(11))
         0: scan = '0;
         1: scan = 32'd1;
         2: scan = '1;
         3: scan = $urandom;
         default: scan = 32'($urandom_range(30, 2));
      endcase
      configure(lo, hi, care_v, len, base, scan);
   endtask

   function automatic logic [7:0] noise_byte();
      if ($urandom_range(1) == 1) return sb.pattern_byte($urandom_range(PATTERN_BYTES - 1));
      return 8'($urandom);
   endfunction

   // random bytes, usually with the pattern planted somewhere, now and then damaged
   function automatic void make_stream(int max_len);
      int len, n, at, back, pos;
      len = sb.active_length();
      n = $urandom_range(max_len, 1);
      stream_q.delete();
      repeat (n) stream_q.push_back(noise_byte());
      if (n >= len && $urandom_range(99) < 70) begin
         at = $urandom_range(n - len, 0);
         // aim at the edge of the allowed start range
         if ($urandom_range(2) == 0 && sb.scan_length <= n - len) begin
            back = $urandom_range(1);
            at = int'(sb.scan_length) - back;
            if (at < 0) at = 0;
         end
         for (int k = 0; k < len; k++)
            if (sb.care[k]) stream_q[at + k] = sb.pattern_byte(k);
         if ($urandom_range(99) < 15) begin
            pos = at + $urandom_range(len - 1);
            stream_q[pos] ^= 8'h01 << $urandom_range(7);
         end
      end
   endfunction

   initial begin
      int phase;
      sb = new();
      sb.reset_regs();
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = REG_PATTERN_LOW;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.data_byte = 8'h00;
      req_ch.last = 1'b0;
      steady = 1'b0;
      hold_request = 0;
      cycles = 0;
      items_sent = 0;
      streams_sent = 0;
      settings_used = 0;
      holds_done = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset values: scan length zero, so nothing can match
      stream_q = '{8'h00};
      send_stream();
      stream_q = '{8'hFF, 8'h5A};
      send_stream();
      drain_and_settle();

      // pattern 01 ?? FF, base just below the address wrap
      configure(64'h0000_0000_00FF_8001, '1, 16'h0005, 5'd3, 64'hFFFF_FFFF_FFFF_FFFE, 32'd4);
      stream_q = '{8'h01, 8'h80};                      // ends before the window fills
      send_stream();
      stream_q = '{8'h01, 8'h00, 8'hFF, 8'h22, 8'h33}; // match at start, quiet afterwards
      send_stream();
      stream_q = '{8'hAA, 8'h55, 8'h01, 8'h37, 8'hFF}; // match on the final byte, wraps
      send_stream();
      stream_q = '{8'h09, 8'h09, 8'h09, 8'h09, 8'h01, 8'h00, 8'hFF}; // start past the limit
      send_stream();
      drain_and_settle();

      configure(64'h0000_0000_0000_00FF, '0, 16'h0001, 5'd0, '0, '1);
      stream_q = '{8'h00, 8'hFF};
      send_stream();

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         drain_and_settle();
         choose_setting();
         steady = (phase == 2);
         if (phase == 4 || phase == 11) begin
            // short streams pile up results while the result side holds off
            hold_request = LONG_HOLD;
            repeat (30) begin
               make_stream(3);
               send_stream();
            end
         end else begin
            repeat ($urandom_range(12, 4)) begin
               make_stream(sb.active_length() + 20);
               send_stream();
            end
         end
         phase++;
      end
      steady = 1'b0;
      drain_and_settle();
      repeat (8) @(negedge clock);

      sb.flush_leftovers();
      $display("Scanned %0d bytes in %0d streams over %0d register settings, %0d long holds.",
               items_sent, streams_sent, settings_used, holds_done);
      $display("Predicted %0d matches and %0d empty reports; %0d mismatches.",
               sb.hits, sb.misses, sb.errors);
      if (sb.errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
